// File: rtl/core/swmm_pkg.sv
// ----------------------------------------------------------------------------
// swmm_pkg
// shared sizes and types for the sliding window min/max/mean unit
// ----------------------------------------------------------------------------
package swmm_pkg;

  // window depth, 2 to 31 (fill_count is FILL_W bits)
  localparam int WINDOW = 20;
  localparam int DATA_W = 32;
  // count of held samples, 0 to WINDOW
  localparam int CNT_W  = $clog2(WINDOW + 1);
  // walk step index, 0 to WINDOW-1
  localparam int IDX_W  = $clog2(WINDOW);
  // sum of a full window never overflows this
  localparam int SUM_W  = DATA_W + $clog2(WINDOW);
  localparam int FILL_W = 5;
  // divider step counter width, steps 0 to DATA_W-1
  localparam int STEP_W = $clog2(DATA_W);

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [SUM_W-1:0]  sum_t;

endpackage

// File: rtl/core/swmm_cell.sv
// ----------------------------------------------------------------------------
// swmm_cell
// one sample stage of the window chain, loads its neighbor when shifting
// ----------------------------------------------------------------------------
module swmm_cell (
  input  logic            clk,
  input  logic            shift_en,
  input  swmm_pkg::data_t neighbor,
  output swmm_pkg::data_t value
);
  import swmm_pkg::*;

  data_t held;

  always_ff @(posedge clk) begin
    if (shift_en) begin
      held <= neighbor;
    end
  end

  assign value = held;

endmodule

// File: rtl/core/swmm_div.sv
// ----------------------------------------------------------------------------
// swmm_div
// restoring divider, one quotient bit per cycle, zero divisor gives zero
// ----------------------------------------------------------------------------
module swmm_div (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  swmm_pkg::sum_t  dividend,
  input  swmm_pkg::cnt_t  divisor,
  output swmm_pkg::data_t quotient,
  output logic            done
);
  import swmm_pkg::*;

  logic              busy;
  logic              zero_div;
  logic [STEP_W-1:0] step;
  cnt_t              dvsr;
  cnt_t              rem;
  data_t             quo;
  logic [CNT_W:0]    trial;
  logic [CNT_W:0]    diff;
  logic              fits;

  // shift the next dividend bit into the partial remainder
  assign trial = {rem, quo[DATA_W-1]};
  assign diff  = trial - {1'b0, dvsr};
  assign fits  = trial >= {1'b0, dvsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
    end else if (busy && step == STEP_W'(DATA_W - 1)) begin
      busy <= 1'b0;
      done <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      // upper dividend bits stay below any nonzero divisor: quotient fits 32 bits
      rem      <= CNT_W'(dividend[SUM_W-1:DATA_W]);
      quo      <= dividend[DATA_W-1:0];
      dvsr     <= divisor;
      zero_div <= (divisor == '0);
      step     <= '0;
    end else if (busy) begin
      rem  <= fits ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo  <= {quo[DATA_W-2:0], fits};
      step <= step + 1'b1;
    end
  end

  assign quotient = zero_div ? '0 : quo;

endmodule

// File: rtl/core/sliding_window_min_max_mean_unit.sv
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_unit
// mean, min, max and interleaved averages over the last WINDOW samples
// ----------------------------------------------------------------------------
// sequence: WINDOW rotation steps, a divider start state, 32 divider steps
//   and the result load, which waits while an earlier result is unaccepted
// throughput: one sample at a time, set by the full-chain rotation and the
//   bit-serial dividers; the next sample is taken only back in idle, which
//   may come while the previous result still waits
// reset: window empty, no result pending; stored samples are left as is
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  swmm_pkg::data_t                 sample,
  output logic                            out_valid,
  input  logic                            out_ready,
  output swmm_pkg::data_t                 window_mean,
  output swmm_pkg::data_t                 window_min,
  output swmm_pkg::data_t                 window_max,
  output swmm_pkg::data_t                 pair_low,
  output swmm_pkg::data_t                 pair_high,
  output logic [swmm_pkg::FILL_W-1:0]     fill_count
);
  import swmm_pkg::*;

  // parity of the window depth, used to find the position parity of the tail
  localparam logic WIN_ODD = 1'(WINDOW % 2);

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_DIV_GO,
    S_DIV
  } state_t;

  state_t          state;
  cnt_t            cnt;       // samples held, newest in cell 0
  logic [IDX_W-1:0] k;        // rotation step
  sum_t            sum;
  sum_t            even_sum;
  sum_t            odd_sum;
  data_t           lo;
  data_t           hi;

  logic            accept;
  logic            walking;
  logic            shift_en;
  data_t           head_in;
  data_t           tail;
  data_t           chain [WINDOW];

  logic [CNT_W:0]  k_plus_n;
  logic            in_win;
  logic            odd_pos;

  cnt_t            even_n;
  cnt_t            odd_n;
  logic            div_start;
  data_t           mean_q;
  data_t           even_q;
  data_t           odd_q;
  logic            mean_done;
  logic            even_done;
  logic            odd_done;
  logic            load;

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign walking  = (state == S_WALK);
  assign shift_en = accept || walking;

  // chain: a new sample enters at the head, the oldest falls off the tail;
  // while walking, the tail is fed back to the head so a full rotation
  // brings every sample past the accumulator and back to its own cell
  assign tail    = chain[WINDOW-1];
  assign head_in = walking ? tail : sample;

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    if (i == 0) begin : g_head
      swmm_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .neighbor (head_in),
        .value    (chain[i])
      );
    end else begin : g_body
      swmm_cell u_cell (
        .clk      (clk),
        .shift_en (shift_en),
        .neighbor (chain[i-1]),
        .value    (chain[i])
      );
    end
  end

  // at step k the tail holds original cell WINDOW-1-k, which holds a sample
  // when that index is below the count; its position from the oldest sample
  // is k + cnt - WINDOW
  assign k_plus_n = (CNT_W+1)'(k) + (CNT_W+1)'(cnt);
  assign in_win   = k_plus_n >= (CNT_W+1)'(WINDOW);
  assign odd_pos  = k[0] ^ cnt[0] ^ WIN_ODD;

  // even class takes the oldest sample, so it has the extra one
  assign even_n = CNT_W'(({1'b0, cnt} + 1'b1) >> 1);
  assign odd_n  = cnt >> 1;

  assign div_start = (state == S_DIV_GO);
  assign load      = (state == S_DIV) && mean_done && even_done && odd_done &&
                     (!out_valid || out_ready);

  swmm_div u_div_mean (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (cnt),
    .quotient (mean_q),
    .done     (mean_done)
  );

  swmm_div u_div_even (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (even_sum),
    .divisor  (even_n),
    .quotient (even_q),
    .done     (even_done)
  );

  swmm_div u_div_odd (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (odd_sum),
    .divisor  (odd_n),
    .quotient (odd_q),
    .done     (odd_done)
  );

  // control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      k         <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      // result payload
      if (load) begin
        window_mean <= mean_q;
        window_min  <= lo;
        window_max  <= hi;
        pair_low    <= (even_q > odd_q) ? odd_q : even_q;
        pair_high   <= (even_q > odd_q) ? even_q : odd_q;
        fill_count  <= FILL_W'(cnt);
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state <= S_WALK;
            k     <= '0;
            if (cnt != CNT_W'(WINDOW)) begin
              cnt <= cnt + 1'b1;
            end
          end
        end
        S_WALK: begin
          if (k == IDX_W'(WINDOW - 1)) begin
            state <= S_DIV_GO;
          end else begin
            k <= k + 1'b1;
          end
        end
        S_DIV_GO: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // accumulators, cleared when a sample enters
  always_ff @(posedge clk) begin
    if (accept) begin
      sum      <= '0;
      even_sum <= '0;
      odd_sum  <= '0;
      lo       <= '1;
      hi       <= '0;
    end else if (walking && in_win) begin
      sum <= sum + SUM_W'(tail);
      if (odd_pos) begin
        odd_sum <= odd_sum + SUM_W'(tail);
      end else begin
        even_sum <= even_sum + SUM_W'(tail);
      end
      if (tail < lo) begin
        lo <= tail;
      end
      if (tail > hi) begin
        hi <= tail;
      end
    end
  end

  // window never holds more than its depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(WINDOW))
    else $error("held count above window depth");

  // a valid result has its mean between min and max
  a_mean_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (window_min <= window_mean) && (window_mean <= window_max))
    else $error("mean outside min/max");

  // the ordered pair stays ordered and inside the max
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pair_low <= pair_high) && (pair_high <= window_max))
    else $error("interleaved averages out of order");

  // a result holds at least one sample
  a_fill_nonzero: assert property (@(posedge clk) disable iff (rst)
    load |-> (cnt != '0))
    else $error("result loaded with empty window");

endmodule

// File: sim/sliding_window_min_max_mean_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_checker
// watches both channels of the window statistics unit, keeps its own copy of
// the sample window, predicts each result and compares it field by field
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_ready,
  input  swmm_pkg::data_t             sample,
  input  logic                        out_valid,
  input  logic                        out_ready,
  input  swmm_pkg::data_t             window_mean,
  input  swmm_pkg::data_t             window_min,
  input  swmm_pkg::data_t             window_max,
  input  swmm_pkg::data_t             pair_low,
  input  swmm_pkg::data_t             pair_high,
  input  logic [swmm_pkg::FILL_W-1:0] fill_count,
  output int                          errors,
  output int                          pending
);
  import swmm_pkg::*;

  typedef struct packed {
    data_t             mean;
    data_t             lo;
    data_t             hi;
    data_t             pair_lo;
    data_t             pair_hi;
    logic [FILL_W-1:0] fill;
  } window_stats_t;

  // held samples, oldest first
  data_t         window_q[$];
  window_stats_t stats_q[$];

  task automatic report_mismatch(input string msg);
    $display("%0t mismatch: %s", $realtime, msg);
    errors = errors + 1;
  endtask

  task automatic check_field(input string name, input data_t got, input data_t want);
    if (got !== want)
      report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // append the sample, drop the oldest when full, then walk the window
  function automatic window_stats_t window_stats(input data_t value);
    logic [63:0]   total;
    logic [63:0]   even_total;
    logic [63:0]   odd_total;
    logic [63:0]   even_avg;
    logic [63:0]   odd_avg;
    logic [63:0]   swap;
    int unsigned   even_n;
    int unsigned   odd_n;
    int unsigned   n;
    data_t         lo;
    data_t         hi;
    window_stats_t r;
    window_q.insert(window_q.size(), value);
    if (window_q.size() > WINDOW)
      window_q.delete(0);
    n = window_q.size();
    total = '0;
    even_total = '0;
    odd_total = '0;
    even_n = 0;
    odd_n = 0;
    lo = '1;
    hi = '0;
    for (int i = 0; i < n; i++) begin
      total += window_q[i];
      if (window_q[i] < lo) lo = window_q[i];
      if (window_q[i] > hi) hi = window_q[i];
      // parity counted from the oldest sample
      if (i % 2 == 0) begin
        even_total += window_q[i];
        even_n++;
      end else begin
        odd_total += window_q[i];
        odd_n++;
      end
    end
    // an empty parity class averages to zero
    even_avg = (even_n != 0) ? even_total / even_n : 64'd0;
    odd_avg = (odd_n != 0) ? odd_total / odd_n : 64'd0;
    if (even_avg > odd_avg) begin
      swap = even_avg;
      even_avg = odd_avg;
      odd_avg = swap;
    end
    r.mean = data_t'(total / n);
    r.lo = lo;
    r.hi = hi;
    r.pair_lo = data_t'(even_avg);
    r.pair_hi = data_t'(odd_avg);
    r.fill = FILL_W'(n);
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    window_stats_t want;
    window_stats_t predicted;
    if (rst) begin
      window_q.delete();
      stats_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      // the older transaction leaves before a new one is predicted
      if (out_valid && out_ready) begin
        if (stats_q.size() == 0) begin
          report_mismatch("result with nothing expected");
        end else begin
          want = stats_q[0];
          stats_q.delete(0);
          check_field("window_mean", window_mean, want.mean);
          check_field("window_min", window_min, want.lo);
          check_field("window_max", window_max, want.hi);
          check_field("pair_low", pair_low, want.pair_lo);
          check_field("pair_high", pair_high, want.pair_hi);
          check_field("fill_count", data_t'(fill_count), data_t'(want.fill));
        end
      end
      if (in_valid && in_ready) begin
        predicted = window_stats(sample);
        stats_q.insert(stats_q.size(), predicted);
      end
      pending <= stats_q.size();
    end
  end

endmodule

// File: sim/sliding_window_min_max_mean_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sliding_window_min_max_mean_unit_tb
// drives directed and random samples into the window statistics unit with random gaps
// on both channels, a long output hold-off and full drains, while a checker
// predicts every result; the verdict needs no pending result and a zero mismatch count
// ----------------------------------------------------------------------------
module sliding_window_min_max_mean_unit_tb;
  import swmm_pkg::*;

  // nominal delay from a taken sample to its result
  localparam int    LATENCY      = WINDOW + 34;
  localparam int    RANDOM_ITEMS = 1475;
  // receiver stops taking results after this many for a long stretch
  localparam int    HOLD_AT      = 400;
  localparam int    HOLD_CYCLES  = 500;
  // cycles without any transaction before the run is declared hung
  localparam int    IDLE_LIMIT   = 4000;
  localparam data_t ALL_ONES     = '1;

  logic              clk;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              out_ready = 1'b0;
  data_t             sample    = '0;
  logic              in_ready;
  logic              out_valid;
  data_t             window_mean;
  data_t             window_min;
  data_t             window_max;
  data_t             pair_low;
  data_t             pair_high;
  logic [FILL_W-1:0] fill_count;
  int                errors;
  int                pending;
  // when set the sender offers back to back
  bit                eager_send = 1'b0;

  sliding_window_min_max_mean_unit dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_mean (window_mean),
    .window_min  (window_min),
    .window_max  (window_max),
    .pair_low    (pair_low),
    .pair_high   (pair_high),
    .fill_count  (fill_count)
  );

  sliding_window_min_max_mean_checker stats_check (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .sample      (sample),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .window_mean (window_mean),
    .window_min  (window_min),
    .window_max  (window_max),
    .pair_low    (pair_low),
    .pair_high   (pair_high),
    .fill_count  (fill_count),
    .errors      (errors),
    .pending     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // offer one sample after a random gap and hold it until the transaction;
  // with no gap valid simply stays high for the next sample
  task automatic send_sample(input data_t value);
    int unsigned gap;
    gap = eager_send ? 0 : $urandom_range(0, 9);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    sample <= value;
    do @(posedge clk); while (!(in_valid && in_ready));
  endtask

  // stop offering and wait for every predicted result to come out;
  // the first edge lets the checker count the last accepted sample
  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // receiver: random stall per result, bursts with no stall, and one long
  // hold-off so the unit fills up and pushes back on its input
  initial begin : receiver
    int unsigned stall;
    int unsigned taken;
    bit          eager;
    taken = 0;
    eager = 1'b0;
    do @(posedge clk); while (rst);
    forever begin
      if (taken % 64 == 0)
        eager = ($urandom_range(0, 3) == 0);
      stall = eager ? 0 : $urandom_range(0, 9);
      if (taken == HOLD_AT)
        stall = HOLD_CYCLES;
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!(out_valid && out_ready));
      taken++;
    end
  end

  // watchdog: any transaction on either channel restarts the count
  initial begin : watchdog
    int unsigned idle;
    idle = 0;
    while (idle < IDLE_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle = 0;
      else
        idle++;
    end
    $display("[sliding_window_min_max_mean_unit] ERROR");
    $finish;
  end

  initial begin : stimulus
    data_t value;
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // lone all-ones sample: odd class empty, so pair_low is zero
    send_sample(ALL_ONES);
    // zero next to all-ones splits min/max and the two parity averages
    send_sample('0);
    // fill the window, then wrap twice so the zero drops out and the sum
    // of a full window of all-ones needs the wide accumulator
    repeat (20) send_sample(ALL_ONES);
    send_sample(32'h0000_0001);
    send_sample(32'h8000_0000);
    send_sample(32'h7fff_ffff);

    // sender pause: nothing goes in until the unit is empty
    wait_drained();

    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 64 == 0)
        eager_send = ($urandom_range(0, 3) == 0);
      if (k == RANDOM_ITEMS / 2)
        wait_drained();
      // half full-range values, the rest small, zero, all-ones or near-top
      // values, so min, max and parity order change often
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: value = $urandom;
        5, 6:          value = $urandom_range(0, 255);
        7:             value = ALL_ONES;
        8:             value = '0;
        default:       value = 32'hffff_ff00 | $urandom_range(0, 255);
      endcase
      send_sample(value);
    end

    wait_drained();
    // let any stray result show up before the verdict
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0 && pending == 0)
      $display("[sliding_window_min_max_mean_unit] OK");
    else
      $display("[sliding_window_min_max_mean_unit] ERROR");
    $finish;
  end

endmodule
